>>> src/hts_pkg.sv
// Shared types and codes for the set-associative handle table.
`timescale 1ns / 1ps

package hts_pkg;

  // Field widths fixed by the item format
  localparam int unsigned HandleW = 32;
  localparam int unsigned PtrW    = 32;
  localparam int unsigned EntryW  = HandleW + PtrW;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StsW    = 2;

  // Operation codes
  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpLookup = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;

  // Result status codes
  localparam logic [StsW-1:0] StsOk      = 2'd0;
  localparam logic [StsW-1:0] StsFull    = 2'd1;
  localparam logic [StsW-1:0] StsUnknown = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write a zero row at the sweep address
    logic accept;  // latch the input item and issue the row read
    logic exec;    // compare the row, write it back, load the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep is at the last row
    logic out_valid;   // result register is occupied
  } sts_t;

endpackage

>>> src/hts_ctrl.sv
// Controller state machine for the handle table: clear sweep, accept, execute.
`timescale 1ns / 1ps

module hts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  hts_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output hts_pkg::cmd_t cmd_o
);
  import hts_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ready;

  // Take an item only when the result register is free by the next edge
  assign ready      = (state_q == StIdle) && (!sts_i.out_valid || out_ready_i);
  assign in_ready_o = ready;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && ready) begin
          cmd_o.accept = 1'b1;
          state_d      = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/hts_dp.sv
// Datapath for the handle table: row memory, way compare, counter, result register.
`timescale 1ns / 1ps

module hts_dp #(
  parameter int unsigned ROW_BITS = 10,
  parameter int unsigned WAY_BITS = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hts_pkg::cmd_t             cmd_i,
  output hts_pkg::sts_t             sts_o,
  input  logic [hts_pkg::OpW-1:0]     operation_i,
  input  logic [hts_pkg::HandleW-1:0] handle_in_i,
  input  logic [hts_pkg::PtrW-1:0]    pointer_in_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [hts_pkg::HandleW-1:0] handle_out_o,
  output logic [hts_pkg::PtrW-1:0]    pointer_out_o,
  output logic                      alive_o,
  output logic [hts_pkg::StsW-1:0]    status_o
);
  import hts_pkg::*;

  localparam int unsigned NumRows = 1 << ROW_BITS;
  localparam int unsigned NumWays = 1 << WAY_BITS;
  localparam int unsigned RowW    = NumWays * EntryW;

  // Row memory, one word holds every way of a row
  logic [RowW-1:0]     mem_q [NumRows];
  logic [RowW-1:0]     rd_q;
  logic [ROW_BITS-1:0] raddr;
  logic [ROW_BITS-1:0] waddr;
  logic [RowW-1:0]     wdata;
  logic                we;

  // Item registers
  logic [OpW-1:0]      op_q;
  logic [HandleW-1:0]  key_q;
  logic [PtrW-1:0]     ptr_q;
  logic [ROW_BITS-1:0] row_q;

  // Handle counter and clear sweep
  logic [HandleW-1:0]  nh_q, nh_d;
  logic [ROW_BITS-1:0] clr_q;

  // Result register
  logic               out_valid_q;
  logic [HandleW-1:0] h_out_q;
  logic [PtrW-1:0]    p_out_q;
  logic               alive_q;
  logic [StsW-1:0]    sts_q;

  // Compare results
  logic [NumWays-1:0] hit, free, hit_oh, free_oh, sel_oh;
  logic               any_hit, any_free, key_nz, do_write;
  logic [PtrW-1:0]    hit_ptr;
  logic [RowW-1:0]    new_row;
  logic [PtrW-1:0]    p_res;
  logic               a_res;
  logic [StsW-1:0]    s_res;

  // Row address: inserts go to the counter's row, others to the given handle's row
  assign raddr = (operation_i == OpInsert) ? nh_q[ROW_BITS-1:0] : handle_in_i[ROW_BITS-1:0];

  // Compare every way of the read row against the key and against free
  always_comb begin
    for (int w = 0; w < NumWays; w++) begin
      hit[w]  = (rd_q[w*EntryW +: HandleW] == key_q);
      free[w] = (rd_q[w*EntryW +: HandleW] == '0);
    end
  end

  // Lowest matching way wins
  assign hit_oh   = hit & (~hit + NumWays'(1));
  assign free_oh  = free & (~free + NumWays'(1));
  assign any_hit  = |hit;
  assign any_free = |free;
  assign key_nz   = (key_q != '0);

  always_comb begin
    hit_ptr = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (hit_oh[w]) begin
        hit_ptr = hit_ptr | rd_q[w*EntryW + HandleW +: PtrW];
      end
    end
  end

  // Operation decode: result fields and row write-back
  always_comb begin
    p_res    = '0;
    a_res    = 1'b0;
    s_res    = StsOk;
    do_write = 1'b0;
    sel_oh   = hit_oh;
    case (op_q)
      OpInsert: begin
        sel_oh = free_oh;
        if (any_free) begin
          do_write = 1'b1;
        end else begin
          s_res = StsFull;
        end
      end
      OpLookup: begin
        if (key_nz && any_hit) begin
          p_res = hit_ptr;
          a_res = (hit_ptr != '0);
        end
      end
      OpRemove: begin
        if (key_nz) begin
          if (any_hit) begin
            do_write = 1'b1;
          end else begin
            s_res = StsUnknown;
          end
        end
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  // Replacement row: insert fills the chosen way, remove zeroes it
  always_comb begin
    new_row = rd_q;
    for (int w = 0; w < NumWays; w++) begin
      if (sel_oh[w]) begin
        if (op_q == OpInsert) begin
          new_row[w*EntryW +: EntryW] = {ptr_q, key_q};
        end else begin
          new_row[w*EntryW +: EntryW] = '0;
        end
      end
    end
  end

  // Memory write port is shared between the sweep and write-back
  assign we    = cmd_i.clear || (cmd_i.exec && do_write);
  assign waddr = cmd_i.clear ? clr_q : row_q;
  assign wdata = cmd_i.clear ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Counter steps on every insert and skips zero on wrap
  always_comb begin
    nh_d = nh_q + HandleW'(1);
    if (nh_d == '0) begin
      nh_d = HandleW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nh_q  <= HandleW'(1);
      clr_q <= '0;
    end else begin
      if (cmd_i.exec && (op_q == OpInsert)) begin
        nh_q <= nh_d;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + ROW_BITS'(1);
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= operation_i;
      key_q <= (operation_i == OpInsert) ? nh_q : handle_in_i;
      ptr_q <= pointer_in_i;
      row_q <= raddr;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      h_out_q <= key_q;
      p_out_q <= p_res;
      alive_q <= a_res;
      sts_q   <= s_res;
    end
  end

  assign sts_o.clear_last = &clr_q;
  assign sts_o.out_valid  = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign handle_out_o  = h_out_q;
  assign pointer_out_o = p_out_q;
  assign alive_o       = alive_q;
  assign status_o      = sts_q;

endmodule

>>> src/handle_table_set_assoc.sv
// Set-associative handle table, top level.
//
// Usage: one input channel (in_valid_i / in_ready_o) carries an operation
// (insert, lookup, remove), a handle and a pointer; one output channel
// (out_valid_o / out_ready_i) returns one result per item: the handle, the
// stored pointer, the alive flag and a status code.
// Each item reads one row of 2**WAY_BITS ways from the row memory, compares
// all ways in parallel, then writes the row back if an insert or remove
// changed it. One item is in flight at a time: the input transfer loads the
// item registers and the row read, the execute state then loads the result
// register; no new item is taken before that pass over the row memory port.
// Reset sets the handle counter to 1 and starts a clearing pass that writes
// a zero row per cycle over all 2**ROW_BITS rows; in_ready_o stays low
// until it finishes.
// The result waits in an output register while the receiver stalls; the next
// item is only taken once that register is free or being emptied in the
// same cycle.
`timescale 1ns / 1ps

module handle_table_set_assoc #(
  parameter int unsigned ROW_BITS = 10,
  parameter int unsigned WAY_BITS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hts_pkg::OpW-1:0]     operation_i,
  input  logic [hts_pkg::HandleW-1:0] handle_in_i,
  input  logic [hts_pkg::PtrW-1:0]    pointer_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hts_pkg::HandleW-1:0] handle_out_o,
  output logic [hts_pkg::PtrW-1:0]    pointer_out_o,
  output logic                        alive_o,
  output logic [hts_pkg::StsW-1:0]    status_o
);
  import hts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  hts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  hts_dp #(
    .ROW_BITS (ROW_BITS),
    .WAY_BITS (WAY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .handle_in_i   (handle_in_i),
    .pointer_in_i  (pointer_in_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .handle_out_o  (handle_out_o),
    .pointer_out_o (pointer_out_o),
    .alive_o       (alive_o),
    .status_o      (status_o)
  );

`ifndef SYNTHESIS
  // Ready only when the result register can take the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while result register is blocked");

  // Every input transfer yields a valid result from the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##2 out_valid_o)
    else $error("result missing two cycles after input transfer");

  // No second item while one is being executed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input ready during execute cycle");

  // Alive implies a nonzero pointer and an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alive_o) |-> (pointer_out_o != '0 && status_o == StsOk))
    else $error("alive result with zero pointer or bad status");
`endif

endmodule
